### src/gbn_pkg.sv
package gbn_pkg;

  localparam int WL_W       = 4;
  localparam int TO_W       = 16;
  localparam int SEQ_PORT_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [WL_W-1:0] WINDOW_LIMIT_RST  = 4'd8;
  localparam logic [TO_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    ACT_SEND,
    ACT_ACK,
    ACT_TICK,
    ACT_NONE
  } action_t;

  typedef enum logic [1:0] {
    KIND_NEW,
    KIND_RETX,
    KIND_REFUSED,
    KIND_STATUS
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_RETX
  } state_t;

  typedef struct packed {
    logic step;
    logic retx_emit;
  } gbn_cmd_t;

  typedef struct packed {
    logic out_free;
    logic expire;
    logic retx_last;
  } gbn_status_t;

endpackage

### src/gbn_in_if.sv
interface gbn_in_if import gbn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [SEQ_PORT_W-1:0] ack_seq;
  logic                  ack_ok;

  modport source (output valid, output action, output ack_seq, output ack_ok, input ready);
  modport sink   (input valid, input action, input ack_seq, input ack_ok, output ready);
endinterface

### src/gbn_out_if.sv
interface gbn_out_if import gbn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [SEQ_PORT_W-1:0] seq_out;
  logic                  last;
  logic                  all_acked;

  modport source (output valid, output kind, output seq_out, output last, output all_acked,
                  input ready);
  modport sink   (input valid, input kind, input seq_out, input last, input all_acked,
                  output ready);
endinterface

### src/gbn_ctrl.sv
module gbn_ctrl import gbn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gbn_status_t status,
  output gbn_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.step      = 1'b0;
    cmd.retx_emit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = status.out_free;
        cmd.step = in_valid && status.out_free;
        if (cmd.step && status.expire) begin
          state_next = ST_RETX;
        end
      end
      ST_RETX: begin
        cmd.retx_emit = status.out_free;
        if (status.out_free && status.retx_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_expire_enters_retx: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.expire) |=> (state == ST_RETX))
    else $error("expiry did not start a retransmit run");

  a_retx_run_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.retx_emit && status.retx_last) |=> (state == ST_IDLE))
    else $error("retransmit run did not end after last beat");

endmodule

### src/gbn_datapath.sv
module gbn_datapath import gbn_pkg::*; #(
  parameter int MAX_WINDOW = 8,
  parameter int SEQ_BITS   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [1:0]            action,
  input  logic [SEQ_PORT_W-1:0] ack_seq,
  input  logic                  ack_ok,
  input  gbn_cmd_t              cmd,
  output gbn_status_t           status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            kind,
  output logic [SEQ_PORT_W-1:0] seq_out,
  output logic                  last,
  output logic                  all_acked
);

  localparam int SEQ_MAX = (1 << SEQ_BITS) - 1;
  localparam int CAP_I   = (MAX_WINDOW < SEQ_MAX) ? MAX_WINDOW : SEQ_MAX;
  localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [SEQ_BITS-1:0] CAP = SEQ_BITS'(CAP_I);
  localparam logic [SEQ_BITS-1:0] SEQ_ONE = SEQ_BITS'(1);

  logic [WL_W-1:0]     window_limit;
  logic [TO_W-1:0]     timeout_ticks;
  logic [SEQ_BITS-1:0] window_base;
  logic [SEQ_BITS-1:0] next_seq;
  logic                timer_running;
  logic [TO_W-1:0]     timer_left;
  logic [IDX_W-1:0]    retx_idx;
  logic [IDX_W-1:0]    retx_last_idx;
  kind_t               kind_r;

  logic [SEQ_BITS-1:0] outs;
  logic [SEQ_BITS-1:0] wl_ext;
  logic [SEQ_BITS-1:0] eff_win;
  logic [SEQ_BITS-1:0] ack_s;
  logic [SEQ_BITS-1:0] ack_next;
  logic                ack_hit;
  logic                grant;
  logic [IDX_W-1:0]    retx_last_val;
  action_t             act;

  assign act      = action_t'(action);
  assign outs     = next_seq - window_base;
  assign wl_ext   = SEQ_BITS'(window_limit);
  assign ack_s    = SEQ_BITS'(ack_seq);
  assign ack_next = ack_s + SEQ_ONE;
  assign ack_hit  = ack_ok && ((ack_s - window_base) < outs);
  assign grant    = outs < eff_win;

  always_comb begin
    if (wl_ext == '0) begin
      eff_win = SEQ_ONE;
    end else if (wl_ext > CAP) begin
      eff_win = CAP;
    end else begin
      eff_win = wl_ext;
    end
  end

  always_comb begin
    if (32'(outs) > 32'(MAX_WINDOW)) begin
      retx_last_val = IDX_W'(MAX_WINDOW - 1);
    end else begin
      retx_last_val = IDX_W'(outs - SEQ_ONE);
    end
  end

  assign status.out_free  = !out_valid || out_ready;
  assign status.expire    = (act == ACT_TICK) && timer_running && (timer_left <= TO_W'(1))
                            && (outs != '0);
  assign status.retx_last = (retx_idx == retx_last_idx);

  assign kind = kind_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit  <= WINDOW_LIMIT_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_WINDOW_LIMIT:  window_limit  <= cfg_data[WL_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base   <= '0;
      next_seq      <= '0;
      timer_running <= 1'b0;
      timer_left    <= '0;
      out_valid     <= 1'b0;
    end else if (cmd.step) begin
      case (act)
        ACT_SEND: begin
          out_valid <= 1'b1;
          last      <= 1'b1;
          if (grant) begin
            if (outs == '0) begin
              timer_running <= 1'b1;
              timer_left    <= timeout_ticks;
            end
            next_seq  <= next_seq + SEQ_ONE;
            kind_r    <= KIND_NEW;
            seq_out   <= SEQ_PORT_W'(next_seq);
            all_acked <= 1'b0;
          end else begin
            kind_r    <= KIND_REFUSED;
            seq_out   <= SEQ_PORT_W'(window_base);
            all_acked <= (outs == '0);
          end
        end
        ACT_ACK: begin
          out_valid <= 1'b1;
          last      <= 1'b1;
          kind_r    <= KIND_STATUS;
          if (ack_hit) begin
            window_base <= ack_next;
            seq_out     <= SEQ_PORT_W'(ack_next);
            all_acked   <= (ack_next == next_seq);
            if (ack_next == next_seq) begin
              timer_running <= 1'b0;
              timer_left    <= '0;
            end else begin
              timer_running <= 1'b1;
              timer_left    <= timeout_ticks;
            end
          end else begin
            seq_out   <= SEQ_PORT_W'(window_base);
            all_acked <= (outs == '0);
          end
        end
        ACT_TICK: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (timer_running) begin
            if (timer_left > TO_W'(1)) begin
              timer_left <= timer_left - TO_W'(1);
            end else if (outs == '0) begin
              timer_running <= 1'b0;
              timer_left    <= '0;
            end else begin
              timer_left    <= timeout_ticks;
              retx_idx      <= '0;
              retx_last_idx <= retx_last_val;
            end
          end
        end
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
      endcase
    end else if (cmd.retx_emit) begin
      out_valid <= 1'b1;
      kind_r    <= KIND_RETX;
      seq_out   <= SEQ_PORT_W'(window_base + SEQ_BITS'(retx_idx));
      last      <= status.retx_last;
      all_acked <= 1'b0;
      retx_idx  <= retx_idx + IDX_W'(1);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_timer_tracks_outstanding: assert property (@(posedge clk) disable iff (rst)
    timer_running == (outs != '0))
    else $error("timer state disagrees with outstanding count");

  a_stopped_timer_clear: assert property (@(posedge clk) disable iff (rst)
    !timer_running |-> (timer_left == '0))
    else $error("stopped timer holds a count");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    outs <= CAP)
    else $error("outstanding count beyond window cap");

endmodule

### src/go_back_n_sender_window.sv
// Send and ack items: one result beat, registered, valid the cycle after accept;
// one item accepted per cycle while the output register is free or being drained.
// Tick items: no beat unless the timer expires; then n = min(outstanding, MAX_WINDOW)
// retransmit beats, one per cycle if the shared output register is free; input held off.
// Synchronous active-high reset: window and timer cleared, output empty,
// window_limit = 8, timeout_ticks = 1000.
module go_back_n_sender_window import gbn_pkg::*; #(
  parameter int MAX_WINDOW = 8,
  parameter int SEQ_BITS   = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gbn_in_if.sink                in_ch,
  gbn_out_if.source             out_ch
);

  gbn_cmd_t    cmd;
  gbn_status_t status;
  logic        in_ready;

  assign in_ch.ready = in_ready;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .action    (in_ch.action),
    .ack_seq   (in_ch.ack_seq),
    .ack_ok    (in_ch.ack_ok),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kind      (out_ch.kind),
    .seq_out   (out_ch.seq_out),
    .last      (out_ch.last),
    .all_acked (out_ch.all_acked)
  );

endmodule
